FILE: design/rbpp_pkg.sv
// rbpp_pkg: shared types, constants and helpers of the round brush pixel painter
// no dependencies; imported by every module of the block
package rbpp_pkg;

  localparam int CH_BITS       = 8;
  localparam int SIZE_BITS     = 12;
  localparam int LIM_BITS      = 2 * SIZE_BITS;
  localparam int BLEND_BITS    = 2 * CH_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = 2;

  localparam logic [CH_BITS-1:0]   MIN_OPACITY  = 8'd3;
  localparam logic [CH_BITS-1:0]   CH_MAX       = 8'd255;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET   = 12'd16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BRUSH_SIZE  = 3'd0,
    CFG_COLOR_BLUE  = 3'd1,
    CFG_COLOR_GREEN = 3'd2,
    CFG_COLOR_RED   = 3'd3,
    CFG_OPACITY     = 3'd4,
    CFG_TRANSPARENT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } bgr_t;

  typedef struct packed {
    bgr_t               color;
    logic [CH_BITS-1:0] opacity;
    logic               trans;
  } brush_cfg_t;

  typedef struct packed {
    logic hit;
    bgr_t orig;
  } entry_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [CH_BITS-1:0] div255(input logic [BLEND_BITS-1:0] x);
    logic [BLEND_BITS-1:0] t;
    t = x + BLEND_BITS'(1) + (x >> CH_BITS);
    return t[BLEND_BITS-1:CH_BITS];
  endfunction

endpackage

FILE: design/rbpp_pix_if.sv
// rbpp_pix_if: input pixel channel, valid/ready with stamp centre and pixel payload
// depends on nothing; widths follow the coordinate parameters
interface rbpp_pix_if #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
);
  logic                            valid;
  logic                            ready;
  logic [COORD_BITS+FRAC_BITS-1:0] center_x;
  logic [COORD_BITS+FRAC_BITS-1:0] center_y;
  logic [COORD_BITS-1:0]           pixel_x;
  logic [COORD_BITS-1:0]           pixel_y;
  logic [7:0]                      orig_blue;
  logic [7:0]                      orig_green;
  logic [7:0]                      orig_red;
  logic                            selected;

  modport source (output valid, center_x, center_y, pixel_x, pixel_y,
                  orig_blue, orig_green, orig_red, selected, input ready);
  modport sink (input valid, center_x, center_y, pixel_x, pixel_y,
                orig_blue, orig_green, orig_red, selected, output ready);
endinterface

FILE: design/rbpp_res_if.sv
// rbpp_res_if: result channel, valid/ready with new pixel value and painted flag
// depends on nothing
interface rbpp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] new_blue;
  logic [7:0] new_green;
  logic [7:0] new_red;
  logic       painted;

  modport source (output valid, new_blue, new_green, new_red, painted, input ready);
  modport sink (input valid, new_blue, new_green, new_red, painted, output ready);
endinterface

FILE: design/rbpp_cfg_if.sv
// rbpp_cfg_if: register write channel, valid/ready with register index and data
// depends on nothing
interface rbpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/round_brush_pixel_painter.sv
// round_brush_pixel_painter: top level, brush registers, front, queue and back
// depends on rbpp_pkg, the rbpp interfaces, rbpp_front, rbpp_queue, rbpp_back
//
//   channel   dir   handshake      payload
//   pixels    in    valid/ready    center_x/y, pixel_x/y, orig_bgr, selected
//   results   out   valid/ready    new_bgr, painted
//   cfg       in    valid/ready    index, data (ready always high)
//
// one pixel per cycle sustained while results are taken; registered path from pixel
// transfer to result valid: two front stages (difference, square), queue, blend, output
// synchronous active-high reset empties the pipeline and queue and loads
// register defaults; no clearing pass
// a stalled result holds the back; the four-entry queue lets the front run on
// until it fills, then pixels.ready drops
module round_brush_pixel_painter import rbpp_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic       clk,
  input  logic       rst,
  rbpp_pix_if.sink   pixels,
  rbpp_res_if.source results,
  rbpp_cfg_if.sink   cfg
);

  logic [SIZE_BITS-1:0] brush_size;
  logic [LIM_BITS-1:0]  lim;
  brush_cfg_t           brush;

  logic   push;
  entry_t push_data;
  logic   full;
  logic   pop;
  logic   nonempty;
  entry_t pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_size  <= SIZE_RESET;
      brush       <= '{color: '0, opacity: CH_MAX, trans: 1'b0};
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_BRUSH_SIZE:  brush_size        <= cfg.data[SIZE_BITS-1:0];
        CFG_COLOR_BLUE:  brush.color.blue  <= cfg.data[CH_BITS-1:0];
        CFG_COLOR_GREEN: brush.color.green <= cfg.data[CH_BITS-1:0];
        CFG_COLOR_RED:   brush.color.red   <= cfg.data[CH_BITS-1:0];
        CFG_OPACITY:     brush.opacity     <= cfg.data[CH_BITS-1:0];
        CFG_TRANSPARENT: brush.trans       <= cfg.data[0];
        default:         brush_size        <= brush_size;
      endcase
    end
  end

  // squared diameter, registered, follows the size register in the next cycle
  always_ff @(posedge clk) begin
    lim <= LIM_BITS'(brush_size) * LIM_BITS'(brush_size);
  end

  rbpp_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .lim       (lim),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  rbpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .pop_data  (pop_data)
  );

  rbpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .brush    (brush),
    .nonempty (nonempty),
    .pop_data (pop_data),
    .pop      (pop),
    .results  (results)
  );

endmodule

FILE: design/rbpp_front.sv
// rbpp_front: accepts pixels, computes squared distance and classifies the hit
// depends on rbpp_pkg and rbpp_pix_if; feeds rbpp_queue
module rbpp_front import rbpp_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                clk,
  input  logic                rst,
  rbpp_pix_if.sink            pixels,
  input  logic [LIM_BITS-1:0] lim,
  input  logic                full,
  output logic                push,
  output entry_t              push_data
);

  localparam int CB = COORD_BITS + FRAC_BITS;
  localparam int SQ = 2 * CB;
  localparam int CW = (SQ + 3 > LIM_BITS) ? SQ + 3 : LIM_BITS;

  logic          en;
  logic [CB-1:0] px;
  logic [CB-1:0] py;
  logic [CB-1:0] dx_next;
  logic [CB-1:0] dy_next;

  logic          s1_valid;
  logic [CB-1:0] dx;
  logic [CB-1:0] dy;
  logic          s1_sel;
  bgr_t          s1_pix;

  logic          s2_valid;
  logic [SQ-1:0] sqx;
  logic [SQ-1:0] sqy;
  logic          s2_sel;
  bgr_t          s2_pix;

  logic [CW-1:0] dist4;
  logic          in_disc;

  assign en           = !s2_valid || !full;
  assign pixels.ready = en;

  assign px      = {pixels.pixel_x, {FRAC_BITS{1'b0}}};
  assign py      = {pixels.pixel_y, {FRAC_BITS{1'b0}}};
  assign dx_next = (px >= pixels.center_x) ? px - pixels.center_x : pixels.center_x - px;
  assign dy_next = (py >= pixels.center_y) ? py - pixels.center_y : pixels.center_y - py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixels.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx     <= dx_next;
      dy     <= dy_next;
      s1_sel <= pixels.selected;
      s1_pix <= '{blue: pixels.orig_blue, green: pixels.orig_green, red: pixels.orig_red};
      sqx    <= SQ'(dx) * SQ'(dx);
      sqy    <= SQ'(dy) * SQ'(dy);
      s2_sel <= s1_sel;
      s2_pix <= s1_pix;
    end
  end

  // distance test in units of 2^-2F, scaled by four against size squared
  assign dist4   = CW'({(SQ+1)'(sqx) + (SQ+1)'(sqy), 2'b00});
  assign in_disc = dist4 <= CW'(lim);

  assign push      = s2_valid && !full;
  assign push_data = '{hit: s2_sel && in_disc, orig: s2_pix};

endmodule

FILE: design/rbpp_queue.sv
// rbpp_queue: short fifo of classified pixels between front and back
// depends on rbpp_pkg
module rbpp_queue import rbpp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output entry_t pop_data
);

  entry_t               mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full     = count == (QPTR_BITS+1)'(QDEPTH);
  assign nonempty = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/rbpp_back.sv
// rbpp_back: blends, writes brush colour or passes the original, and drives the result register
// depends on rbpp_pkg and rbpp_res_if; drains rbpp_queue
module rbpp_back import rbpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  brush_cfg_t brush,
  input  logic       nonempty,
  input  entry_t     pop_data,
  output logic       pop,
  rbpp_res_if.source results
);

  logic                  en_o;
  logic                  en_b;
  logic                  paint_next;
  logic [CH_BITS-1:0]    inv_a;

  logic                  b1_valid;
  logic                  b1_paint;
  bgr_t                  b1_orig;
  logic [BLEND_BITS-1:0] sum_b;
  logic [BLEND_BITS-1:0] sum_g;
  logic [BLEND_BITS-1:0] sum_r;

  logic                  o_valid;
  logic                  o_painted;
  bgr_t                  o_pix;

  assign en_o  = !o_valid || results.ready;
  assign en_b  = !b1_valid || en_o;
  assign pop   = nonempty && en_b;
  assign inv_a = CH_MAX - brush.opacity;

  assign paint_next = pop_data.hit && (!brush.trans || brush.opacity >= MIN_OPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (en_b) begin
        b1_valid <= pop;
      end
      if (en_o) begin
        o_valid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b1_paint <= paint_next;
      b1_orig  <= pop_data.orig;
      sum_b    <= BLEND_BITS'(brush.color.blue) * BLEND_BITS'(brush.opacity)
                + BLEND_BITS'(pop_data.orig.blue) * BLEND_BITS'(inv_a);
      sum_g    <= BLEND_BITS'(brush.color.green) * BLEND_BITS'(brush.opacity)
                + BLEND_BITS'(pop_data.orig.green) * BLEND_BITS'(inv_a);
      sum_r    <= BLEND_BITS'(brush.color.red) * BLEND_BITS'(brush.opacity)
                + BLEND_BITS'(pop_data.orig.red) * BLEND_BITS'(inv_a);
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_painted <= b1_paint;
      if (!b1_paint) begin
        o_pix <= b1_orig;
      end else if (brush.trans) begin
        o_pix <= '{blue: div255(sum_b), green: div255(sum_g), red: div255(sum_r)};
      end else begin
        o_pix <= brush.color;
      end
    end
  end

  assign results.valid     = o_valid;
  assign results.new_blue  = o_pix.blue;
  assign results.new_green = o_pix.green;
  assign results.new_red   = o_pix.red;
  assign results.painted   = o_painted;

endmodule

FILE: dv/rbpp_paint_checker.sv
// rbpp_paint_checker: watches the pixel, result and register channels of the painter,
// predicts the result of each pixel and compares results in order
// depends on rbpp_pkg and the rbpp interfaces
module rbpp_paint_checker import rbpp_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  rbpp_pix_if         pix,
  rbpp_res_if         res,
  rbpp_cfg_if         cfg,
  output int unsigned pending,
  output int unsigned fail_count
);

  localparam int POS_BITS    = COORD_BITS + FRAC_BITS;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    bgr_t color;
    logic painted;
  } painted_px_t;

  logic [SIZE_BITS-1:0] size_q;
  bgr_t                 color_q;
  logic [CH_BITS-1:0]   opacity_q;
  logic                 trans_q;
  painted_px_t          painted_px_q[$];
  painted_px_t          want;
  int unsigned          mismatches = 0;
  int unsigned          result_no = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    if (mismatches < MAX_REPORTS)
      $display("%s mismatch at result %0d: got %0h, want %0h", what, result_no, got, exp_val);
    mismatches++;
  endtask

  function automatic logic [CH_BITS-1:0] mix_channel(input logic [CH_BITS-1:0] col,
                                                     input logic [CH_BITS-1:0] orig,
                                                     input logic [CH_BITS-1:0] alpha);
    int unsigned acc;
    acc = col * alpha + orig * (CH_MAX - alpha);
    return CH_BITS'(acc / CH_MAX);
  endfunction

  function automatic painted_px_t paint_pixel(input logic [POS_BITS-1:0] cx,
                                              input logic [POS_BITS-1:0] cy,
                                              input logic [COORD_BITS-1:0] px,
                                              input logic [COORD_BITS-1:0] py,
                                              input bgr_t orig, input logic sel);
    logic [POS_BITS-1:0] fx, fy;
    longint unsigned     dx, dy, dist4, reach2;
    logic                visible;
    painted_px_t         r;
    fx = {px, {FRAC_BITS{1'b0}}};
    fy = {py, {FRAC_BITS{1'b0}}};
    dx = (fx >= cx) ? fx - cx : cx - fx;
    dy = (fy >= cy) ? fy - cy : cy - fy;
    // compare 4*d^2 with size^2 so the half diameter stays exact
    dist4 = (dx * dx + dy * dy) * 4;
    reach2 = size_q;
    reach2 = reach2 * reach2;
    visible = !trans_q || (opacity_q >= MIN_OPACITY);
    r.painted = sel && (dist4 <= reach2) && visible;
    r.color = orig;
    if (r.painted) begin
      if (trans_q) begin
        r.color.blue  = mix_channel(color_q.blue, orig.blue, opacity_q);
        r.color.green = mix_channel(color_q.green, orig.green, opacity_q);
        r.color.red   = mix_channel(color_q.red, orig.red, opacity_q);
      end else begin
        r.color = color_q;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      size_q = SIZE_RESET;
      color_q = '0;
      opacity_q = CH_MAX;
      trans_q = 1'b0;
      painted_px_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_BRUSH_SIZE:  size_q = cfg.data[SIZE_BITS-1:0];
          CFG_COLOR_BLUE:  color_q.blue = cfg.data[CH_BITS-1:0];
          CFG_COLOR_GREEN: color_q.green = cfg.data[CH_BITS-1:0];
          CFG_COLOR_RED:   color_q.red = cfg.data[CH_BITS-1:0];
          CFG_OPACITY:     opacity_q = cfg.data[CH_BITS-1:0];
          CFG_TRANSPARENT: trans_q = cfg.data[0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        painted_px_q.push_back(paint_pixel(pix.center_x, pix.center_y, pix.pixel_x,
                                           pix.pixel_y,
                                           {pix.orig_blue, pix.orig_green, pix.orig_red},
                                           pix.selected));
      if (res.valid && res.ready) begin
        result_no++;
        if (painted_px_q.size() == 0) begin
          report_mismatch("unexpected transfer, painted", res.painted, 0);
        end else begin
          want = painted_px_q.pop_front();
          if (res.new_blue !== want.color.blue)
            report_mismatch("new_blue", res.new_blue, want.color.blue);
          if (res.new_green !== want.color.green)
            report_mismatch("new_green", res.new_green, want.color.green);
          if (res.new_red !== want.color.red)
            report_mismatch("new_red", res.new_red, want.color.red);
          if (res.painted !== want.painted)
            report_mismatch("painted", res.painted, want.painted);
        end
      end
    end
    pending <= painted_px_q.size();
    fail_count <= mismatches;
  end

endmodule

FILE: dv/tb.sv
// tb: drives round_brush_pixel_painter with directed then random pixels and brush settings
// depends on rbpp_pkg, the rbpp interfaces, the block and rbpp_paint_checker
module tb;
  import rbpp_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int FRAC_BITS      = 4;
  localparam int POS_BITS       = COORD_BITS + FRAC_BITS;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int POS_MAX        = (1 << POS_BITS) - 1;
  localparam int SIZE_MAX       = (1 << SIZE_BITS) - 1;
  localparam int DATA_MAX       = (1 << CFG_DATA_BITS) - 1;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_PIXELS   = 45;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [POS_BITS-1:0]   cx;
    logic [POS_BITS-1:0]   cy;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    bgr_t                  orig;
    logic                  sel;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int          hold_cycles = 0;
  int unsigned cur_size = SIZE_RESET;

  rbpp_pix_if #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) pix_if ();
  rbpp_res_if res_if ();
  rbpp_cfg_if cfg_if ();

  round_brush_pixel_painter #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_if),
    .results(res_if),
    .cfg    (cfg_if)
  );

  rbpp_paint_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_chk (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix_if),
    .res       (res_if),
    .cfg       (cfg_if),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** round_brush_pixel_painter: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned rand_field(input int unsigned maxv);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return maxv;
      default: return $urandom_range(0, maxv);
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(input logic [POS_BITS-1:0] c,
                                                       input int reach);
    int t;
    t = int'(c >> FRAC_BITS) + int'($urandom_range(0, 2 * reach)) - reach;
    if (t < 0) t = 0;
    if (t > COORD_MAX) t = COORD_MAX;
    return COORD_BITS'(t);
  endfunction

  function automatic pixel_t mk_pixel(input int unsigned cx, input int unsigned cy,
                                      input int unsigned px, input int unsigned py,
                                      input bit sel);
    pixel_t p;
    p.cx = POS_BITS'(cx);
    p.cy = POS_BITS'(cy);
    p.px = COORD_BITS'(px);
    p.py = COORD_BITS'(py);
    p.orig.blue = CH_BITS'(rand_field(CH_MAX));
    p.orig.green = CH_BITS'(rand_field(CH_MAX));
    p.orig.red = CH_BITS'(rand_field(CH_MAX));
    p.sel = sel;
    return p;
  endfunction

  // mostly pixels around the stamp so the disc edge gets hit, some anywhere
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     reach;
    reach = int'(cur_size >> (FRAC_BITS + 1)) + 2;
    p = mk_pixel(rand_field(POS_MAX), rand_field(POS_MAX), rand_field(COORD_MAX),
                 rand_field(COORD_MAX), $urandom_range(0, 4) != 0);
    if ($urandom_range(0, 6) != 0) begin
      p.px = near_coord(p.cx, reach);
      p.py = near_coord(p.cy, reach);
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.center_x <= p.cx;
    pix_if.center_y <= p.cy;
    pix_if.pixel_x <= p.px;
    pix_if.pixel_y <= p.py;
    pix_if.orig_blue <= p.orig.blue;
    pix_if.orig_green <= p.orig.green;
    pix_if.orig_red <= p.orig.red;
    pix_if.selected <= p.sel;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_brush(input int unsigned size, input int unsigned blue,
                           input int unsigned green, input int unsigned red,
                           input int unsigned op, input int unsigned trans);
    cfg_write(CFG_BRUSH_SIZE, CFG_DATA_BITS'(size));
    cfg_write(CFG_COLOR_BLUE, CFG_DATA_BITS'(blue));
    cfg_write(CFG_COLOR_GREEN, CFG_DATA_BITS'(green));
    cfg_write(CFG_COLOR_RED, CFG_DATA_BITS'(red));
    cfg_write(CFG_OPACITY, CFG_DATA_BITS'(op));
    cfg_write(CFG_TRANSPARENT, CFG_DATA_BITS'(trans));
    cfg_write(CFG_SPARE_A, CFG_DATA_BITS'($urandom));
    cfg_write(CFG_SPARE_B, CFG_DATA_BITS'($urandom));
    cfg_if.valid <= 1'b0;
    cur_size = size & SIZE_MAX;
  endtask

  initial begin : result_sink
    int wait_n;
    res_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      wait_n = sink_idle ? $urandom_range(0, 15) : 0;
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end
      if (wait_n > 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin : stimulus
    pixel_t      pt;
    int unsigned op;
    pix_if.valid <= 1'b0;
    pix_if.center_x <= '0;
    pix_if.center_y <= '0;
    pix_if.pixel_x <= '0;
    pix_if.pixel_y <= '0;
    pix_if.orig_blue <= '0;
    pix_if.orig_green <= '0;
    pix_if.orig_red <= '0;
    pix_if.selected <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset brush: half pixel radius, black, opaque
    sink_idle = 1'b1;
    send_pixel(mk_pixel(160, 160, 10, 10, 1'b1));
    send_pixel(mk_pixel(160, 160, 10, 10, 1'b0));
    send_pixel(mk_pixel(168, 160, 10, 10, 1'b1));
    send_pixel(mk_pixel(169, 160, 10, 10, 1'b1));
    drain();

    // opaque mode ignores opacity, upper data bits dropped
    set_brush(32, 'hFA5, 'h13C, 'h07E, 0, 0);
    send_pixel(mk_pixel(0, 0, 0, 0, 1'b1));
    send_pixel(mk_pixel(1600, 1600, 101, 100, 1'b1));
    send_pixel(mk_pixel(1600, 1600, 101, 101, 1'b1));
    send_pixel(mk_pixel(POS_MAX, POS_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_pixel(mk_pixel(0, 0, COORD_MAX, COORD_MAX, 1'b1));
    send_pixel(mk_pixel(POS_MAX, POS_MAX, 0, 0, 1'b1));
    send_pixel(mk_pixel(0, 0, 0, 0, 1'b0));
    drain();

    // too transparent to paint
    set_brush(64, 40, 200, 120, 2, 1);
    send_pixel(mk_pixel(800, 800, 50, 50, 1'b1));
    drain();

    // lowest visible opacity, blend against both original extremes
    set_brush(64, 'h0FF, 0, 'h380, 3, 'hFFF);
    pt = mk_pixel(800, 800, 50, 50, 1'b1);
    pt.orig = '0;
    send_pixel(pt);
    pt.orig = '1;
    send_pixel(pt);
    drain();

    set_brush(64, 255, 0, 128, 255, 1);
    send_pixel(mk_pixel(800, 800, 50, 51, 1'b1));
    drain();

    // zero size paints only a pixel exactly on the centre
    set_brush(0, 7, 8, 9, 100, 0);
    send_pixel(mk_pixel(800, 960, 50, 60, 1'b1));
    send_pixel(mk_pixel(801, 960, 50, 60, 1'b1));
    drain();

    set_brush(SIZE_MAX, 'hFFF, 'hFFF, 'hFFF, 'hF80, 'hFFE);
    send_pixel(mk_pixel(POS_MAX, POS_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send_pixel(mk_pixel(0, 0, 127, 0, 1'b1));
    send_pixel(mk_pixel(0, 0, 128, 0, 1'b1));
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      op = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : rand_field(DATA_MAX);
      set_brush(rand_field(SIZE_MAX), rand_field(DATA_MAX), rand_field(DATA_MAX),
                rand_field(DATA_MAX), op, $urandom_range(0, DATA_MAX));
      src_idle = (ph != 0) && ($urandom_range(0, 2) != 0);
      sink_idle = (ph != 0) && ($urandom_range(0, 2) != 0);
      if (ph == PRESSURE_PHASE) begin
        // sink holds off while pixels keep coming so the queue fills
        src_idle = 1'b0;
        sink_idle = 1'b0;
        hold_cycles = HOLD_CYCLES;
      end
      repeat (PHASE_PIXELS) send_pixel(rand_pixel());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** round_brush_pixel_painter: PASSED **");
    else
      $display("** round_brush_pixel_painter: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
design/rbpp_pkg.sv
design/rbpp_pix_if.sv
design/rbpp_res_if.sv
design/rbpp_cfg_if.sv
design/rbpp_front.sv
design/rbpp_queue.sv
design/rbpp_back.sv
design/round_brush_pixel_painter.sv
dv/rbpp_paint_checker.sv
dv/tb.sv
